// ===== sv/gffs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffs_pkg
// Shared types and codes for the FIRST / FOLLOW / nullable set engine.
// ----------------------------------------------------------------------------
package gffs_pkg;

    localparam int SYM_W = 6;   // symbol index field width
    localparam int OP_W  = 3;   // opcode field width

    typedef enum logic [OP_W-1:0] {
        OP_DECL    = 3'd0,
        OP_BEGIN   = 3'd1,
        OP_APPEND  = 3'd2,
        OP_COMPUTE = 3'd3,
        OP_CLEAR   = 3'd4
    } gffs_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD,
        ST_HEADW,
        ST_BODY,
        ST_NULL,
        ST_FACC,
        ST_FHW,
        ST_TRD,
        ST_FOW,
        ST_NEXT,
        ST_CLR,
        ST_ESCAN,
        ST_EOUT
    } gffs_state_t;

    // Grammar load request toward the rule store.
    typedef struct packed {
        logic             begin_rule;
        logic             append;
        logic             clear;
        logic             sym_ok;
        logic [SYM_W-1:0] symbol;
    } gffs_load_t;

endpackage

// ===== sv/gffs_rule_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffs_rule_store
// Rule head/length memory and rule body memory, with the load bookkeeping.
// ----------------------------------------------------------------------------
module gffs_rule_store
    import gffs_pkg::*;
#(
    parameter int MAX_RULES = 64,
    parameter int MAX_BODY  = 8,
    parameter int RW        = 6,
    parameter int CW        = 7,
    parameter int KW        = 3,
    parameter int LW        = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  gffs_load_t       load,
    output logic             drop,
    output logic [CW-1:0]    rule_count,
    input  logic [RW-1:0]    rd_rule,
    input  logic [KW-1:0]    rd_k,
    output logic [SYM_W-1:0] rd_head,
    output logic [LW-1:0]    rd_len,
    output logic [SYM_W-1:0] rd_body
);

    localparam int RDEPTH = 2 ** RW;
    localparam int BDEPTH = 2 ** (RW + KW);

    logic [SYM_W+LW-1:0] rule_mem [RDEPTH];
    logic [SYM_W-1:0]    body_mem [BDEPTH];

    logic [CW-1:0]       count_reg;
    logic                open_reg;
    logic [LW-1:0]       cur_len_reg;
    logic [SYM_W-1:0]    cur_head_reg;
    logic [SYM_W+LW-1:0] rule_rd_reg;
    logic [SYM_W-1:0]    body_rd_reg;

    logic          full;
    logic          begin_ok;
    logic          app_ok;
    logic [CW-1:0] last_idx;

    assign full     = (count_reg == CW'(MAX_RULES));
    assign begin_ok = load.begin_rule && load.sym_ok && !full;
    assign app_ok   = load.append && load.sym_ok && open_reg
                      && (cur_len_reg != LW'(MAX_BODY));
    assign drop     = (load.begin_rule && !begin_ok) || (load.append && !app_ok);
    assign last_idx = count_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            open_reg  <= 1'b0;
        end
        else if (load.clear)
        begin
            count_reg <= '0;
            open_reg  <= 1'b0;
        end
        else if (load.begin_rule)
        begin
            if (begin_ok)
            begin
                count_reg <= count_reg + CW'(1);
                open_reg  <= 1'b1;
            end
            else
            begin
                open_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (begin_ok)
        begin
            cur_len_reg  <= '0;
            cur_head_reg <= load.symbol;
            rule_mem[count_reg[RW-1:0]] <= {load.symbol, LW'(0)};
        end
        else if (app_ok)
        begin
            cur_len_reg <= cur_len_reg + LW'(1);
            rule_mem[last_idx[RW-1:0]] <= {cur_head_reg, cur_len_reg + LW'(1)};
            body_mem[{last_idx[RW-1:0], cur_len_reg[KW-1:0]}] <= load.symbol;
        end
        rule_rd_reg <= rule_mem[rd_rule];
        body_rd_reg <= body_mem[{rd_rule, rd_k}];
    end

    assign rule_count = count_reg;
    assign rd_head    = rule_rd_reg[SYM_W+LW-1:LW];
    assign rd_len     = rule_rd_reg[LW-1:0];
    assign rd_body    = body_rd_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RULES))
        else $error("rule count past table size");

    a_open_has_rule: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (count_reg != '0))
        else $error("open rule without any rule");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg |-> (cur_len_reg <= LW'(MAX_BODY)))
        else $error("open body past limit");

endmodule

// ===== sv/gffs_set_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gffs_set_store
// FIRST and FOLLOW set memories, one read and one write port each,
// registered read with write-to-read forwarding.
// ----------------------------------------------------------------------------
module gffs_set_store
#(
    parameter int SETW = 64,
    parameter int SW   = 6
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [SW-1:0]   first_rd_addr,
    input  logic [SW-1:0]   follow_rd_addr,
    input  logic            first_wr_en,
    input  logic [SW-1:0]   first_wr_addr,
    input  logic [SETW-1:0] first_wr_data,
    input  logic            follow_wr_en,
    input  logic [SW-1:0]   follow_wr_addr,
    input  logic [SETW-1:0] follow_wr_data,
    output logic [SETW-1:0] first_rd_data,
    output logic [SETW-1:0] follow_rd_data
);

    logic [SETW-1:0] first_mem  [SETW];
    logic [SETW-1:0] follow_mem [SETW];

    logic [SETW-1:0] first_q_reg, follow_q_reg;
    logic [SW-1:0]   first_ra_reg, follow_ra_reg;
    logic [SW-1:0]   first_wa_reg, follow_wa_reg;
    logic [SETW-1:0] first_wd_reg, follow_wd_reg;
    logic            first_we_reg, follow_we_reg;

    always_ff @(posedge clk)
    begin
        if (first_wr_en)
        begin
            first_mem[first_wr_addr] <= first_wr_data;
        end
        if (follow_wr_en)
        begin
            follow_mem[follow_wr_addr] <= follow_wr_data;
        end
        first_q_reg   <= first_mem[first_rd_addr];
        follow_q_reg  <= follow_mem[follow_rd_addr];
        first_ra_reg  <= first_rd_addr;
        follow_ra_reg <= follow_rd_addr;
        first_wa_reg  <= first_wr_addr;
        follow_wa_reg <= follow_wr_addr;
        first_wd_reg  <= first_wr_data;
        follow_wd_reg <= follow_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_we_reg  <= 1'b0;
            follow_we_reg <= 1'b0;
        end
        else
        begin
            first_we_reg  <= first_wr_en;
            follow_we_reg <= follow_wr_en;
        end
    end

    // a write on the same edge as the read wins
    assign first_rd_data  = (first_we_reg && first_wa_reg == first_ra_reg)
                            ? first_wd_reg : first_q_reg;
    assign follow_rd_data = (follow_we_reg && follow_wa_reg == follow_ra_reg)
                            ? follow_wd_reg : follow_q_reg;

endmodule

// ===== sv/grammar_first_follow_sets.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grammar_first_follow_sets
// FIRST / FOLLOW / nullable computation over a grammar loaded item by item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: s_tuser carries the opcode, s_tdata the symbol and the
//   terminal flag. Declare, begin-rule, append and clear items produce
//   nothing. A compute item returns one item per symbol seen in any rule,
//   in index order, on m_*; m_tlast marks the last one.
//   Compute order: a presence scan over each rule, a pass over all
//   MAX_SYMBOLS entries that rewrites both set memories, then fixed-point
//   passes over all rules, each rule making 1..len FIRST reads over its
//   nullable prefix (none for an empty body), repeated until a pass
//   changes nothing (the last pass confirms).
//   Emission steps through every index and sends one item per present symbol.
//   Cost is set by the single read port on each set memory and on the rule
//   memories.
//   s_tready is high only while idle; the next item waits until the whole
//   compute run has been handed to the output register.
//   A stalled receiver holds the result in the output register and freezes
//   emission. Reset clears the grammar, marks, nullable flags and the sticky
//   error; the set memories need no clearing since a compute rewrites them first.
// ----------------------------------------------------------------------------
module grammar_first_follow_sets
    import gffs_pkg::*;
#(
    parameter int MAX_SYMBOLS = 64,
    parameter int MAX_RULES   = 64,
    parameter int MAX_BODY    = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [5:0] symbol_id, [6] terminal_flag, [7] zero
    input  logic [2:0]   s_tuser,   // [2:0] opcode
    output logic         m_tvalid,
    input  logic         m_tready,
    // [5:0] out_symbol, [6] is_nullable, [70:7] first_bits,
    // [134:71] follow_bits, [135] overflow_seen
    output logic [135:0] m_tdata,
    output logic         m_tlast    // last_of_run
);

    localparam int SETW = MAX_SYMBOLS;
    localparam int SW   = $clog2(MAX_SYMBOLS);
    localparam int EW   = $clog2(MAX_SYMBOLS + 1);
    localparam int RW   = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
    localparam int CW   = $clog2(MAX_RULES + 1);
    localparam int KW   = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
    localparam int LW   = $clog2(MAX_BODY + 1);

    gffs_state_t      state_reg, state_next;
    logic [SETW-1:0]  term_reg, term_next;
    logic [SETW-1:0]  present_reg, present_next;
    logic [SETW-1:0]  nullable_reg, nullable_next;
    logic             err_reg, err_next;
    logic [CW-1:0]    r_reg, r_next;
    logic [LW-1:0]    k_reg, k_next;
    logic [SYM_W-1:0] head_reg, head_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [SYM_W-1:0] body_reg [MAX_BODY];
    logic [SYM_W-1:0] body_next [MAX_BODY];
    logic [SETW-1:0]  acc_reg, acc_next;
    logic [SETW-1:0]  trail_reg, trail_next;
    logic             changed_reg, changed_next;
    logic             scan_reg, scan_next;
    logic [EW-1:0]    s_reg, s_next;

    logic             m_valid_reg, m_valid_next;
    logic [SYM_W-1:0] out_sym_reg, out_sym_next;
    logic             out_null_reg, out_null_next;
    logic [SETW-1:0]  out_first_reg, out_first_next;
    logic [SETW-1:0]  out_follow_reg, out_follow_next;
    logic             out_err_reg, out_err_next;
    logic             out_last_reg, out_last_next;

    // store interfaces
    gffs_load_t       load;
    logic             drop;
    logic [CW-1:0]    rule_count;
    logic [RW-1:0]    rd_rule;
    logic [KW-1:0]    rd_k;
    logic [SYM_W-1:0] rd_head;
    logic [LW-1:0]    rd_len;
    logic [SYM_W-1:0] rd_body;

    logic [SW-1:0]    fa, oa, fwa, owa;
    logic             fwe, owe;
    logic [SETW-1:0]  fwd, owd, first_rd, follow_rd;

    // decode and helpers
    gffs_op_t         op;
    logic [SYM_W-1:0] in_sym;
    logic             in_flag;
    logic             sym_ok;
    logic             accept;
    logic [SYM_W-1:0] cur_body, next_body, prev_body, last_body;
    logic [LW-1:0]    k_inc, k_dec, len_dec;
    logic             all_null;
    logic [SETW-1:0]  merged, upper;
    logic             is_last;

    assign op       = gffs_op_t'(s_tuser);
    assign in_sym   = s_tdata[5:0];
    assign in_flag  = s_tdata[6];
    assign sym_ok   = (int'(in_sym) < MAX_SYMBOLS);
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign k_inc     = k_reg + LW'(1);
    assign k_dec     = k_reg - LW'(1);
    assign len_dec   = len_reg - LW'(1);
    assign cur_body  = body_reg[k_reg[KW-1:0]];
    assign next_body = body_reg[k_inc[KW-1:0]];
    assign prev_body = body_reg[k_dec[KW-1:0]];
    assign last_body = body_reg[len_dec[KW-1:0]];
    assign upper     = present_reg >> s_reg[SW-1:0];
    assign is_last   = ((upper >> 1) == '0);

    always_comb
    begin
        all_null = 1'b1;
        for (int i = 0; i < MAX_BODY; i++)
        begin
            if (LW'(i) < len_reg && !nullable_reg[body_reg[i][SW-1:0]])
            begin
                all_null = 1'b0;
            end
        end
    end

    gffs_rule_store #(
        .MAX_RULES (MAX_RULES),
        .MAX_BODY  (MAX_BODY),
        .RW        (RW),
        .CW        (CW),
        .KW        (KW),
        .LW        (LW)
    ) u_rules (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .drop       (drop),
        .rule_count (rule_count),
        .rd_rule    (rd_rule),
        .rd_k       (rd_k),
        .rd_head    (rd_head),
        .rd_len     (rd_len),
        .rd_body    (rd_body)
    );

    gffs_set_store #(
        .SETW (SETW),
        .SW   (SW)
    ) u_sets (
        .clk            (clk),
        .rst_n          (rst_n),
        .first_rd_addr  (fa),
        .follow_rd_addr (oa),
        .first_wr_en    (fwe),
        .first_wr_addr  (fwa),
        .first_wr_data  (fwd),
        .follow_wr_en   (owe),
        .follow_wr_addr (owa),
        .follow_wr_data (owd),
        .first_rd_data  (first_rd),
        .follow_rd_data (follow_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        term_next       = term_reg;
        present_next    = present_reg;
        nullable_next   = nullable_reg;
        err_next        = err_reg;
        r_next          = r_reg;
        k_next          = k_reg;
        head_next       = head_reg;
        len_next        = len_reg;
        body_next       = body_reg;
        acc_next        = acc_reg;
        trail_next      = trail_reg;
        changed_next    = changed_reg;
        scan_next       = scan_reg;
        s_next          = s_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_sym_next    = out_sym_reg;
        out_null_next   = out_null_reg;
        out_first_next  = out_first_reg;
        out_follow_next = out_follow_reg;
        out_err_next    = out_err_reg;
        out_last_next   = out_last_reg;

        load            = '0;
        load.sym_ok     = sym_ok;
        load.symbol     = in_sym;
        rd_rule         = r_reg[RW-1:0];
        rd_k            = k_reg[KW-1:0];
        fa              = s_reg[SW-1:0];
        oa              = s_reg[SW-1:0];
        fwe             = 1'b0;
        owe             = 1'b0;
        fwa             = s_reg[SW-1:0];
        owa             = s_reg[SW-1:0];
        fwd             = '0;
        owd             = '0;
        merged          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_DECL:
                        begin
                            if (sym_ok)
                            begin
                                term_next[in_sym[SW-1:0]] = in_flag;
                            end
                            else
                            begin
                                err_next = 1'b1;
                            end
                        end
                        OP_BEGIN:
                        begin
                            load.begin_rule = 1'b1;
                            if (drop)
                            begin
                                err_next = 1'b1;
                            end
                        end
                        OP_APPEND:
                        begin
                            load.append = 1'b1;
                            if (drop)
                            begin
                                err_next = 1'b1;
                            end
                        end
                        OP_COMPUTE:
                        begin
                            nullable_next = '0;
                            r_next        = '0;
                            s_next        = '0;
                            changed_next  = 1'b0;
                            if (rule_count != '0)
                            begin
                                scan_next  = 1'b1;
                                state_next = ST_HEAD;
                            end
                            else
                            begin
                                state_next = ST_CLR;
                            end
                        end
                        OP_CLEAR:
                        begin
                            load.clear    = 1'b1;
                            term_next     = '0;
                            present_next  = '0;
                            nullable_next = '0;
                            err_next      = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_HEAD:
            begin
                state_next = ST_HEADW;
            end

            ST_HEADW:
            begin
                head_next = rd_head;
                len_next  = rd_len;
                k_next    = '0;
                if (scan_reg)
                begin
                    present_next[rd_head[SW-1:0]] = 1'b1;
                end
                if (rd_len == '0)
                begin
                    state_next = scan_reg ? ST_NEXT : ST_NULL;
                end
                else
                begin
                    rd_k       = '0;
                    state_next = ST_BODY;
                end
            end

            ST_BODY:
            begin
                body_next[k_reg[KW-1:0]] = rd_body;
                if (scan_reg)
                begin
                    present_next[rd_body[SW-1:0]] = 1'b1;
                end
                if (k_inc == len_reg)
                begin
                    state_next = scan_reg ? ST_NEXT : ST_NULL;
                end
                else
                begin
                    k_next = k_inc;
                    rd_k   = k_inc[KW-1:0];
                end
            end

            ST_NULL:
            begin
                acc_next = '0;
                if (all_null && !nullable_reg[head_reg[SW-1:0]])
                begin
                    nullable_next[head_reg[SW-1:0]] = 1'b1;
                    changed_next = 1'b1;
                end
                if (len_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    k_next     = '0;
                    fa         = body_reg[0][SW-1:0];
                    state_next = ST_FACC;
                end
            end

            // FIRST(head) gathers FIRST of each body symbol behind a nullable prefix
            ST_FACC:
            begin
                acc_next = acc_reg | first_rd;
                if (nullable_reg[cur_body[SW-1:0]] && k_inc < len_reg)
                begin
                    k_next = k_inc;
                    fa     = next_body[SW-1:0];
                end
                else
                begin
                    fa         = head_reg[SW-1:0];
                    state_next = ST_FHW;
                end
            end

            ST_FHW:
            begin
                merged = first_rd | acc_reg;
                if (merged != first_rd)
                begin
                    fwe          = 1'b1;
                    fwa          = head_reg[SW-1:0];
                    fwd          = merged;
                    changed_next = 1'b1;
                end
                oa         = head_reg[SW-1:0];
                state_next = ST_TRD;
            end

            ST_TRD:
            begin
                trail_next = follow_rd;
                k_next     = len_dec;
                fa         = last_body[SW-1:0];
                oa         = last_body[SW-1:0];
                state_next = ST_FOW;
            end

            // backward sweep: trail is what may follow body[k]
            ST_FOW:
            begin
                merged = follow_rd | trail_reg;
                if (merged != follow_rd)
                begin
                    owe          = 1'b1;
                    owa          = cur_body[SW-1:0];
                    owd          = merged;
                    changed_next = 1'b1;
                end
                trail_next = first_rd
                             | (nullable_reg[cur_body[SW-1:0]] ? trail_reg : '0);
                if (k_reg == '0)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    k_next = k_dec;
                    fa     = prev_body[SW-1:0];
                    oa     = prev_body[SW-1:0];
                end
            end

            ST_NEXT:
            begin
                if (r_reg + CW'(1) == rule_count)
                begin
                    if (scan_reg)
                    begin
                        scan_next  = 1'b0;
                        s_next     = '0;
                        state_next = ST_CLR;
                    end
                    else if (changed_reg)
                    begin
                        r_next       = '0;
                        changed_next = 1'b0;
                        state_next   = ST_HEAD;
                    end
                    else
                    begin
                        s_next     = '0;
                        state_next = ST_ESCAN;
                    end
                end
                else
                begin
                    r_next     = r_reg + CW'(1);
                    state_next = ST_HEAD;
                end
            end

            // rewrite both set memories: present terminals seed FIRST with themselves
            ST_CLR:
            begin
                fwe = 1'b1;
                owe = 1'b1;
                if (present_reg[s_reg[SW-1:0]] && term_reg[s_reg[SW-1:0]])
                begin
                    fwd = SETW'(1) << s_reg[SW-1:0];
                end
                if (s_reg == EW'(MAX_SYMBOLS - 1))
                begin
                    s_next       = '0;
                    r_next       = '0;
                    changed_next = 1'b0;
                    state_next   = (rule_count != '0) ? ST_HEAD : ST_ESCAN;
                end
                else
                begin
                    s_next = s_reg + EW'(1);
                end
            end

            ST_ESCAN:
            begin
                if (s_reg == EW'(MAX_SYMBOLS))
                begin
                    state_next = ST_IDLE;
                end
                else if (present_reg[s_reg[SW-1:0]])
                begin
                    state_next = ST_EOUT;
                end
                else
                begin
                    s_next = s_reg + EW'(1);
                end
            end

            ST_EOUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next    = 1'b1;
                    out_sym_next    = SYM_W'(s_reg);
                    out_null_next   = nullable_reg[s_reg[SW-1:0]];
                    out_first_next  = first_rd;
                    out_follow_next = follow_rd;
                    out_err_next    = err_reg;
                    out_last_next   = is_last;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        s_next     = s_reg + EW'(1);
                        state_next = ST_ESCAN;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            term_reg     <= '0;
            present_reg  <= '0;
            nullable_reg <= '0;
            err_reg      <= 1'b0;
            r_reg        <= '0;
            k_reg        <= '0;
            changed_reg  <= 1'b0;
            scan_reg     <= 1'b0;
            s_reg        <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            term_reg     <= term_next;
            present_reg  <= present_next;
            nullable_reg <= nullable_next;
            err_reg      <= err_next;
            r_reg        <= r_next;
            k_reg        <= k_next;
            changed_reg  <= changed_next;
            scan_reg     <= scan_next;
            s_reg        <= s_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg       <= head_next;
        len_reg        <= len_next;
        body_reg       <= body_next;
        acc_reg        <= acc_next;
        trail_reg      <= trail_next;
        out_sym_reg    <= out_sym_next;
        out_null_reg   <= out_null_next;
        out_first_reg  <= out_first_next;
        out_follow_reg <= out_follow_next;
        out_err_reg    <= out_err_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_err_reg, 64'(out_follow_reg), 64'(out_first_reg),
                       out_null_reg, out_sym_reg};

    a_null_present: assert property (@(posedge clk) disable iff (!rst_n)
        (nullable_reg & ~present_reg) == '0)
        else $error("nullable symbol not present");

    a_rule_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HEAD) |-> (r_reg < rule_count))
        else $error("rule index past rule count");

    a_sweep_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOW || state_reg == ST_FACC) |-> (k_reg < len_reg))
        else $error("body index past rule length");

endmodule
